### hw/rtl/vpso_pkg.sv
package vpso_pkg;

  // Shared divider geometry: widest dividend is the bend numerator v*x*2^16.
  localparam int unsigned DIV_NUM_W = 49;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned DIV_CNT_W = 6;

  // Shared multiplier geometry.
  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic signed [MUL_W-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [MUL_W-1:0] ONE_Q30    = 34'sd1073741824;

  localparam logic [31:0] INC_RESET  = 32'd0;
  localparam logic [15:0] INFL_RESET = 16'd32768;
  localparam logic [15:0] VERT_RESET = 16'd4096;
  localparam logic        MODE_RESET = 1'b0;

  typedef enum logic [1:0] {
    REG_INC  = 2'd0,
    REG_INFL = 2'd1,
    REG_VERT = 2'd2,
    REG_MODE = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] infl;
    logic [15:0] vert;
    logic        mode;
  } cfg_t;

  // Taylor series denominators, innermost term first.
  function automatic logic [7:0] cos_den(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd132;
      3'd1:    r = 8'd90;
      3'd2:    r = 8'd56;
      3'd3:    r = 8'd30;
      3'd4:    r = 8'd12;
      default: r = 8'd2;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] sin_den(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'd110;
      3'd1:    r = 8'd72;
      3'd2:    r = 8'd42;
      3'd3:    r = 8'd20;
      default: r = 8'd6;
    endcase
    return r;
  endfunction

  // Reciprocals floor(2^32 / den) of the series denominators above.
  function automatic logic [31:0] cos_rcp(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'd32537631;
      3'd1:    r = 32'd47721858;
      3'd2:    r = 32'd76695844;
      3'd3:    r = 32'd143165576;
      3'd4:    r = 32'd357913941;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sin_rcp(input logic [2:0] idx);
    logic [31:0] r;
    case (idx)
      3'd0:    r = 32'd39045157;
      3'd1:    r = 32'd59652323;
      3'd2:    r = 32'd102261126;
      3'd3:    r = 32'd214748364;
      default: r = 32'd715827882;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/vpso_div.sv
module vpso_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [vpso_pkg::DIV_NUM_W-1:0]       dividend_i,
  input  logic [vpso_pkg::DIV_DEN_W-1:0]       divisor_i,
  input  logic [vpso_pkg::DIV_CNT_W-1:0]       nbits_i,
  output logic                                 done_o,
  output logic [vpso_pkg::DIV_NUM_W-1:0]       quot_o
);

  localparam int unsigned NW = vpso_pkg::DIV_NUM_W;
  localparam int unsigned DW = vpso_pkg::DIV_DEN_W;
  localparam int unsigned CW = vpso_pkg::DIV_CNT_W;

  logic          busy_q, busy_d, done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   trial;
  logic          fit;

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[NW-1]};
    fit    = (trial >= {1'b0, den_q});
    if (start_i) begin
      quo_d  = dividend_i << (CW'(NW) - nbits_i);
      rem_d  = '0;
      den_d  = divisor_i;
      cnt_d  = nbits_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fit ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_d = {quo_q[NW-2:0], fit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hw/rtl/vpso_seq.sv
module vpso_seq #(
  parameter int unsigned COSINE_TABLE_BITS = 10,
  parameter int unsigned SAMPLE_BITS       = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [15:0]            x_i,
  input  vpso_pkg::cfg_t         cfg_i,
  output logic                   ready_o,
  output logic                   res_valid_o,
  input  logic                   res_take_i,
  output logic [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned KW = COSINE_TABLE_BITS;
  localparam int unsigned RW = COSINE_TABLE_BITS - 2;
  localparam int unsigned SH = 43 - SAMPLE_BITS;
  localparam int unsigned MW = vpso_pkg::MUL_W;
  localparam int unsigned PW = vpso_pkg::PROD_W;
  localparam int unsigned NW = vpso_pkg::DIV_NUM_W;
  localparam int unsigned DW = vpso_pkg::DIV_DEN_W;
  localparam int unsigned CW = vpso_pkg::DIV_CNT_W;

  typedef enum logic [24:0] {
    S_IDLE    = 25'd1 << 0,
    S_BEND    = 25'd1 << 1,
    S_BMUL    = 25'd1 << 2,
    S_BDIVS   = 25'd1 << 3,
    S_BDIVW   = 25'd1 << 4,
    S_TDIVS   = 25'd1 << 5,
    S_TDIVW   = 25'd1 << 6,
    S_TMUL    = 25'd1 << 7,
    S_TY      = 25'd1 << 8,
    S_ANG     = 25'd1 << 9,
    S_ANG2    = 25'd1 << 10,
    S_SQ      = 25'd1 << 11,
    S_SQ2     = 25'd1 << 12,
    S_SERMUL  = 25'd1 << 13,
    S_SERQ    = 25'd1 << 14,
    S_RMUL    = 25'd1 << 15,
    S_REST    = 25'd1 << 16,
    S_RCHK    = 25'd1 << 17,
    S_RREM    = 25'd1 << 18,
    S_RFIX    = 25'd1 << 19,
    S_FMUL    = 25'd1 << 20,
    S_FIN     = 25'd1 << 21,
    S_MIX     = 25'd1 << 22,
    S_ACC     = 25'd1 << 23,
    S_DONE    = 25'd1 << 24
  } state_e;

  state_e state_q, state_d;

  logic [15:0]            x_q, x_d, t_q, t_d;
  logic                   two_q, two_d, vidx_q, vidx_d, sin_q, sin_d, neg_q, neg_d;
  logic [11:0]            g_q, g_d;
  logic [17:0]            vcur_q, vcur_d, v2_q, v2_d;
  logic [KW-1:0]          k_q, k_d;
  logic [1:0]             quad_q, quad_d;
  logic [2:0]             iter_q, iter_d;
  logic [31:0]            a_q, a_d;
  logic [32:0]            a2_q, a2_d;
  logic signed [MW-1:0]   c_q, c_d, s_q, s_d;
  logic signed [31:0]     val_q, val_d;
  logic signed [44:0]     m_q, m_d;
  logic signed [PW-1:0]   prod_q, prod_d;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic [32:0]            num_q, num_d, qest_q, qest_d;
  logic [9:0]             rem_q, rem_d;

  logic                   div_start, div_done;
  logic [NW-1:0]          div_num, div_quot;
  logic [DW-1:0]          div_den;
  logic [CW-1:0]          div_n;

  logic signed [37:0]     qt;
  logic [37:0]            qmag;
  logic signed [MW-1:0]   qq, qres;
  logic [27:0]            y_hi;
  logic signed [31:0]     cc, sc;
  logic [12:0]            wgt;
  logic [7:0]             den_cur;
  logic [31:0]            rcp_cur;
  logic signed [44:0]     negm, bias, qs, hi_lim, lo_lim, sat;

  // Signed product over 2^30, truncated toward zero.
  function automatic logic signed [37:0] trunc30(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] b;
    b = p + (p < 0 ? PW'(64'sd1073741823) : PW'(64'sd0));
    return 38'(b >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp_unit(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd1073741824)       r = 32'sd1073741824;
    else if (v < -38'sd1073741824) r = -32'sd1073741824;
    else                           r = 32'(v);
    return r;
  endfunction

  assign prod_d  = mul_a * mul_b;
  assign qt      = trunc30(prod_q);
  assign qmag    = (qt < 0) ? 38'(-qt) : 38'(qt);
  assign qq      = MW'(qest_q);
  assign qres    = neg_q ? -qq : qq;
  assign y_hi    = prod_q[27:0] + {t_q, 12'b0};
  assign cc      = clamp_unit(38'(c_q));
  assign sc      = clamp_unit(qt);
  assign wgt     = vidx_q ? {1'b0, g_q} : (13'd4096 - {1'b0, g_q});
  assign den_cur = sin_q ? vpso_pkg::sin_den(iter_q) : vpso_pkg::cos_den(iter_q);
  assign rcp_cur = sin_q ? vpso_pkg::sin_rcp(iter_q) : vpso_pkg::cos_rcp(iter_q);

  // Shared multiplier operand select.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_BMUL: begin
        mul_a = MW'(vcur_q);
        mul_b = MW'(x_q);
      end
      S_TMUL: begin
        mul_a = MW'(vcur_q);
        mul_b = MW'(17'd65536 - {1'b0, t_q});
      end
      S_ANG: begin
        mul_a = MW'(k_q[RW-1:0]);
        mul_b = vpso_pkg::TWO_PI_Q30;
      end
      S_SQ: begin
        mul_a = MW'(a_q);
        mul_b = MW'(a_q);
      end
      S_SERMUL: begin
        mul_a = MW'(a2_q);
        mul_b = sin_q ? s_q : c_q;
      end
      S_RMUL: begin
        mul_a = MW'(num_q);
        mul_b = MW'(rcp_cur);
      end
      S_RCHK: begin
        mul_a = MW'(qest_q);
        mul_b = MW'(den_cur);
      end
      S_FMUL: begin
        mul_a = MW'(a_q);
        mul_b = s_q;
      end
      S_MIX: begin
        mul_a = MW'(val_q);
        mul_b = MW'(wgt);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Shared divider operand select.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    div_n     = '0;
    unique case (state_q)
      S_BDIVS: begin
        div_start = 1'b1;
        div_num   = {prod_q[32:0], 16'b0};
        div_den   = {1'b0, cfg_i.infl};
        div_n     = CW'(NW);
      end
      S_TDIVS: begin
        div_start = 1'b1;
        div_num   = NW'({x_q - cfg_i.infl, 16'b0});
        div_den   = 17'd65536 - {1'b0, cfg_i.infl};
        div_n     = CW'(32);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  vpso_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .nbits_i    (div_n),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    t_d     = t_q;
    two_d   = two_q;
    vidx_d  = vidx_q;
    sin_d   = sin_q;
    neg_d   = neg_q;
    g_d     = g_q;
    vcur_d  = vcur_q;
    v2_d    = v2_q;
    k_d     = k_q;
    quad_d  = quad_q;
    iter_d  = iter_q;
    a_d     = a_q;
    a2_d    = a2_q;
    c_d     = c_q;
    s_d     = s_q;
    val_d   = val_q;
    m_d     = m_q;
    num_d   = num_q;
    qest_d  = qest_q;
    rem_d   = rem_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          x_d    = x_i;
          m_d    = '0;
          vidx_d = 1'b0;
          two_d  = cfg_i.mode && (cfg_i.vert > 16'd4096);
          if (cfg_i.mode && (cfg_i.vert > 16'd4096)) begin
            // v1 = v with its low 11 bits cleared, gain = twice those bits
            g_d    = {cfg_i.vert[10:0], 1'b0};
            vcur_d = {2'b0, cfg_i.vert[15:11], 11'b0};
            v2_d   = {2'b0, cfg_i.vert[15:11], 11'b0} + 18'd2048;
          end else begin
            g_d    = '0;
            vcur_d = {2'b0, cfg_i.vert};
          end
          state_d = S_BEND;
        end
      end
      S_BEND:  state_d = (x_q < cfg_i.infl) ? S_BMUL : S_TDIVS;
      S_BMUL:  state_d = S_BDIVS;
      S_BDIVS: state_d = S_BDIVW;
      S_BDIVW: begin
        if (div_done) begin
          k_d     = div_quot[27:28-KW];
          state_d = S_ANG;
        end
      end
      S_TDIVS: state_d = S_TDIVW;
      S_TDIVW: begin
        if (div_done) begin
          t_d     = div_quot[15:0];
          state_d = S_TMUL;
        end
      end
      S_TMUL: state_d = S_TY;
      S_TY: begin
        k_d     = y_hi[27:28-KW];
        state_d = S_ANG;
      end
      S_ANG: begin
        quad_d  = k_q[KW-1:KW-2];
        state_d = S_ANG2;
      end
      S_ANG2: begin
        a_d     = prod_q[KW+31:KW];
        state_d = S_SQ;
      end
      S_SQ: state_d = S_SQ2;
      S_SQ2: begin
        a2_d    = prod_q[62:30];
        c_d     = vpso_pkg::ONE_Q30;
        s_d     = vpso_pkg::ONE_Q30;
        iter_d  = '0;
        sin_d   = 1'b0;
        state_d = S_SERMUL;
      end
      S_SERMUL: state_d = S_SERQ;
      S_SERQ: begin
        // Hold the magnitude of the term; the sign comes back after the divide.
        neg_d   = (qt < 0);
        num_d   = qmag[32:0];
        state_d = S_RMUL;
      end
      S_RMUL: state_d = S_REST;
      S_REST: begin
        // Estimate is at most two below the true quotient.
        qest_d  = prod_q[64:32];
        state_d = S_RCHK;
      end
      S_RCHK: state_d = S_RREM;
      S_RREM: begin
        rem_d   = 10'(num_q - prod_q[32:0]);
        state_d = S_RFIX;
      end
      S_RFIX: begin
        if (rem_q >= {2'b0, den_cur}) begin
          qest_d = qest_q + 33'd1;
          rem_d  = rem_q - {2'b0, den_cur};
        end else begin
          if (sin_q) s_d = vpso_pkg::ONE_Q30 - qres;
          else       c_d = vpso_pkg::ONE_Q30 - qres;
          if (!sin_q && iter_q == 3'd5) begin
            sin_d   = 1'b1;
            iter_d  = '0;
            state_d = S_SERMUL;
          end else if (sin_q && iter_q == 3'd4) begin
            state_d = S_FMUL;
          end else begin
            iter_d  = iter_q + 3'd1;
            state_d = S_SERMUL;
          end
        end
      end
      S_FMUL: state_d = S_FIN;
      S_FIN: begin
        unique case (quad_q)
          2'd0: val_d = cc;
          2'd1: val_d = -sc;
          2'd2: val_d = -cc;
          2'd3: val_d = sc;
        endcase
        state_d = S_MIX;
      end
      S_MIX: state_d = S_ACC;
      S_ACC: begin
        m_d = m_q + 45'($signed(prod_q[43:0]));
        if (two_q && !vidx_q) begin
          vidx_d  = 1'b1;
          vcur_d  = v2_q;
          state_d = S_BEND;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iter_q  <= '0;
      sin_q   <= 1'b0;
      vidx_q  <= 1'b0;
      two_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      sin_q   <= sin_d;
      vidx_q  <= vidx_d;
      two_q   <= two_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    t_q    <= t_d;
    neg_q  <= neg_d;
    g_q    <= g_d;
    vcur_q <= vcur_d;
    v2_q   <= v2_d;
    k_q    <= k_d;
    quad_q <= quad_d;
    a_q    <= a_d;
    a2_q   <= a2_d;
    c_q    <= c_d;
    s_q    <= s_d;
    val_q  <= val_d;
    m_q    <= m_d;
    prod_q <= prod_d;
    num_q  <= num_d;
    qest_q <= qest_d;
    rem_q  <= rem_d;
  end

  // Negate, scale toward zero, saturate.
  assign negm   = -m_q;
  assign bias   = (negm < 0) ? ((45'sd1 <<< SH) - 45'sd1) : 45'sd0;
  assign qs     = (negm + bias) >>> SH;
  assign hi_lim = (45'sd1 <<< (SAMPLE_BITS - 1)) - 45'sd1;
  assign lo_lim = -(45'sd1 <<< (SAMPLE_BITS - 1));
  assign sat    = (qs > hi_lim) ? hi_lim : ((qs < lo_lim) ? lo_lim : qs);

  assign sample_o    = sat[SAMPLE_BITS-1:0];
  assign ready_o     = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_BDIVW || state_q == S_TDIVW))
    else $error("divider finished outside a wait state");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("request started while busy");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_take_i) |=> (state_q == S_DONE && $stable(m_q)))
    else $error("result dropped before handoff");

  a_iter_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q <= 3'd5)
    else $error("series step counter out of range");

endmodule

### hw/rtl/vector_phaseshaping_oscillator_core.sv
// Vector phaseshaping oscillator.
// Input channel (in_valid_i / in_stall_o / block_last_i): each request asks
// for one audio sample. A request is taken when in_valid_i is high and
// in_stall_o is low; the phase accumulator advances on that edge.
// Output channel (out_valid_o / out_stall_i / sample_o / last_o): one result
// per request, in order, with last_o copying block_last_i of its request.
// Configuration: write cfg_data_i to register cfg_idx_i while cfg_we_i is
// high (0 increment, 1 inflection d, 2 vertical v, 3 ratio mode). Write only
// while no request is in flight.
// In ratio mode with v above one, two voices are worked out in turn. The
// bend division runs on a shared one-bit-per-cycle divider; the eleven
// Taylor series divisions by small constants are reciprocal multiplies
// with a short correction on the shared 34x34 multiplier. One request is
// worked on at a time.
// The output register lets the next request enter while a sample waits.
// Reset: phase goes to zero and the registers to their defaults; the block
// is ready right after reset. While out_stall_i is high the sample holds,
// and once the sequencer has finished the next sample it stalls the input.
module vector_phaseshaping_oscillator_core #(
  parameter int unsigned PHASE_BITS        = 32,
  parameter int unsigned COSINE_TABLE_BITS = 10,
  parameter int unsigned SAMPLE_BITS       = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   block_last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] sample_o,
  output logic                   last_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i
);

  localparam int unsigned INC_SHL = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
  localparam int unsigned INC_SHR = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
  localparam int unsigned WIDE_W  = PHASE_BITS + 32;

  logic [PHASE_BITS-1:0]  phase_q, phase_d, inc_al;
  logic [WIDE_W-1:0]      inc_wide;
  logic [31:0]            inc_q;
  logic [15:0]            infl_q, vert_q;
  logic                   mode_q;
  vpso_pkg::cfg_t         cfg;
  logic                   seq_ready, accept, res_valid, res_take;
  logic [SAMPLE_BITS-1:0] seq_sample, sample_q;
  logic                   pend_last_q, last_q, out_valid_q;

  // Align the 32-bit increment to the accumulator's fraction.
  assign inc_wide = (WIDE_W'(inc_q) << INC_SHL) >> INC_SHR;
  assign inc_al   = inc_wide[PHASE_BITS-1:0];
  assign phase_d  = phase_q + inc_al;

  assign accept     = in_valid_i && seq_ready;
  assign in_stall_o = !seq_ready;

  assign cfg.infl = infl_q;
  assign cfg.vert = vert_q;
  assign cfg.mode = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q  <= vpso_pkg::INC_RESET;
      infl_q <= vpso_pkg::INFL_RESET;
      vert_q <= vpso_pkg::VERT_RESET;
      mode_q <= vpso_pkg::MODE_RESET;
    end else if (cfg_we_i) begin
      unique case (vpso_pkg::reg_idx_e'(cfg_idx_i))
        vpso_pkg::REG_INC:  inc_q  <= cfg_data_i;
        vpso_pkg::REG_INFL: infl_q <= cfg_data_i[15:0];
        vpso_pkg::REG_VERT: vert_q <= cfg_data_i[15:0];
        vpso_pkg::REG_MODE: mode_q <= cfg_data_i[0];
      endcase
    end
  end

  // Advance the phase on each accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pend_last_q <= block_last_i;
  end

  vpso_seq #(
    .COSINE_TABLE_BITS (COSINE_TABLE_BITS),
    .SAMPLE_BITS       (SAMPLE_BITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .x_i         (phase_d[PHASE_BITS-1 -: 16]),
    .cfg_i       (cfg),
    .ready_o     (seq_ready),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .sample_o    (seq_sample)
  );

  // Output register: load when empty or being drained this cycle.
  assign res_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      sample_q <= seq_sample;
      last_q   <= pend_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = sample_q;
  assign last_o      = last_q;

endmodule

### dv/vector_phaseshaping_oscillator_core_tb.sv
module vector_phaseshaping_oscillator_core_tb;

  localparam longint QONE      = 64'sd1 <<< 30;
  localparam longint TWO_PI    = 64'sd6746518852;
  localparam int     WDOG_MAX  = 40000;
  localparam int     LONG_HOLD = 6000;

  typedef struct packed {
    logic [15:0] smp;
    logic        last;
  } sample_t;

  // Bit-exact model of the oscillator plus the queue of samples still owed.
  class osc_scoreboard;
    logic [31:0] phase;
    logic [31:0] inc;
    logic [15:0] infl;
    logic [15:0] vert;
    logic        mode;
    sample_t     owed[$];
    int          errors;

    function new();
      phase  = '0;
      inc    = vpso_pkg::INC_RESET;
      infl   = vpso_pkg::INFL_RESET;
      vert   = vpso_pkg::VERT_RESET;
      mode   = vpso_pkg::MODE_RESET;
      errors = 0;
    endfunction

    function void set_reg(vpso_pkg::reg_idx_e idx, logic [31:0] data);
      case (idx)
        vpso_pkg::REG_INC:  inc  = data;
        vpso_pkg::REG_INFL: infl = data[15:0];
        vpso_pkg::REG_VERT: vert = data[15:0];
        vpso_pkg::REG_MODE: mode = data[0];
        default: ;
      endcase
    endfunction

    function longint qmul(longint a, longint b);
      return (a * b) / QONE;
    endfunction

    function longint clamp1(longint a);
      if (a > QONE) return QONE;
      if (a < -QONE) return -QONE;
      return a;
    endfunction

    // Cosine of the phase k/1024 of a full period in Q2.30, quarter-wave fold plus Taylor series.
    function longint cos_q30(longint unsigned k);
      longint cden[6];
      longint sden[5];
      longint unsigned quad, r;
      longint a, a2, c, s;
      cden = '{132, 90, 56, 30, 12, 2};
      sden = '{110, 72, 42, 20, 6};
      quad = (k >> 8) & 3;
      r    = k & 255;
      a    = longint'((r * longint'(TWO_PI)) >> 10);
      a2   = qmul(a, a);
      c    = QONE;
      s    = QONE;
      for (int i = 0; i < 6; i++) c = QONE - qmul(a2, c) / cden[i];
      for (int i = 0; i < 5; i++) s = QONE - qmul(a2, s) / sden[i];
      s = qmul(a, s);
      c = clamp1(c);
      s = clamp1(s);
      case (quad)
        0: return c;
        1: return -s;
        2: return -c;
        default: return s;
      endcase
    endfunction

    // Bent phase in Q.28; v may exceed the register width in ratio mode.
    function longint unsigned bend_q28(longint unsigned x, longint unsigned v);
      longint unsigned d, t;
      d = infl;
      if (x < d) return ((v * x) << 16) / d;
      t = ((x - d) << 16) / (65536 - d);
      return v * (65536 - t) + (t << 12);
    endfunction

    function longint voice(longint unsigned x, longint unsigned v);
      longint unsigned f;
      f = bend_q28(x, v) & ((64'd1 << 28) - 1);
      return cos_q30(f >> 18);
    endfunction

    // Advance the phase for an accepted request and queue its sample.
    function void note_request(logic last);
      longint unsigned x, v, g, v1;
      longint m, s;
      sample_t exp_s;
      phase = phase + inc;
      x = phase[31:16];
      v = vert;
      if (!mode || v <= 4096) begin
        m = voice(x, v) * 4096;
      end else begin
        g  = (2 * v - 4096) & 4095;
        v1 = (2 * v - g) / 2;
        m  = voice(x, v1) * longint'(4096 - g) + voice(x, v1 + 2048) * longint'(g);
      end
      s = (-m) / (64'sd1 <<< 27);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      exp_s.smp  = s[15:0];
      exp_s.last = last;
      owed.push_back(exp_s);
    endfunction

    function void check_sample(logic [15:0] smp, logic last);
      sample_t exp_s;
      if (owed.size() == 0) begin
        $display("%0t: unexpected sample %0d last %0b", $time, $signed(smp), last);
        errors++;
        return;
      end
      exp_s = owed.pop_front();
      if (smp !== exp_s.smp) begin
        $display("%0t: sample mismatch expected %0d actual %0d", $time,
                 $signed(exp_s.smp), $signed(smp));
        errors++;
      end
      if (last !== exp_s.last) begin
        $display("%0t: last mismatch expected %0b actual %0b", $time, exp_s.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        block_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] sample_o;
  logic        last_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  osc_scoreboard sb = new();

  // Idling percentages, changed between phases by the stimulus process.
  int tx_idle_pct = 36;
  int rx_idle_pct = 53;
  int hold_left   = 0;
  int quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  vector_phaseshaping_oscillator_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .block_last_i (block_last_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_o     (sample_o),
    .last_o       (last_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  // Monitor both channels at the edge; values seen here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(block_last_i);
      if (out_valid_o && !out_stall_i) sb.check_sample(sample_o, last_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk_i) begin
    if (quiet_cycles >= WDOG_MAX) begin
      $display("vector_phaseshaping_oscillator_core regression: fail");
      $finish;
    end
  end

  // Write all four registers on consecutive edges; mirror them in the model.
  task automatic write_regs(logic [31:0] inc, logic [15:0] d, logic [15:0] v, logic m);
    logic [31:0] data [4];
    data[0] = inc;
    data[1] = {16'($urandom_range(65535)), d};
    data[2] = {16'($urandom_range(65535)), v};
    data[3] = {31'($urandom()), m};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= vpso_pkg::reg_idx_e'(i);
      cfg_data_i <= data[i];
      sb.set_reg(vpso_pkg::reg_idx_e'(i), data[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic last);
    bit taken;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i   <= 1'b1;
    block_last_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Drop valid and let the block drain before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic run_requests(int n);
    for (int i = 0; i < n; i++) send_request(($urandom_range(7) == 0) || (i == n - 1));
    drain();
  endtask

  initial begin
    logic [15:0] d, v;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults with zero increment, both values of last.
    send_request(1'b0);
    send_request(1'b1);
    drain();
    // Bent phase lands on half a cycle: full-scale positive saturates.
    write_regs(32'h8000_0000, 16'd32768, 16'd2048, 1'b0);
    run_requests(4);
    // Zero inflection point, maximum v in ratio mode: upper voice beyond range.
    write_regs(32'hFFFF_FFFF, 16'd0, 16'hFFFF, 1'b1);
    run_requests(4);
    // Smallest inflection point, v zero.
    write_regs(32'h0100_0000, 16'd1, 16'd0, 1'b1);
    run_requests(4);
    // Largest inflection point, crossfade with a fractional gain.
    write_regs(32'h1234_5678, 16'hFFFF, 16'd6000, 1'b1);
    run_requests(5);

    // Random phases: idle pattern moves from receiver-heavy to sender-heavy to none.
    for (int p = 0; p < 12; p++) begin
      if (p == 4) begin
        tx_idle_pct = 53;
        rx_idle_pct = 36;
      end else if (p == 8) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case ($urandom_range(3))
        0: d = 16'd1;
        1: d = 16'hFFFF;
        default: d = 16'($urandom_range(65535));
      endcase
      case ($urandom_range(3))
        0: v = 16'hFFFF;
        1: v = 16'($urandom_range(4096));
        default: v = 16'($urandom_range(65535));
      endcase
      write_regs($urandom(), d, v, 1'($urandom_range(1)));
      // Hold the output off for a long stretch so the input backs up.
      if (p == 9) hold_left = LONG_HOLD;
      run_requests(48);
    end

    if (sb.errors == 0)
      $display("vector_phaseshaping_oscillator_core regression: pass");
    else
      $display("vector_phaseshaping_oscillator_core regression: fail");
    $finish;
  end

endmodule

### vector_phaseshaping_oscillator_core.f
hw/rtl/vpso_pkg.sv
hw/rtl/vpso_div.sv
hw/rtl/vpso_seq.sv
hw/rtl/vector_phaseshaping_oscillator_core.sv
dv/vector_phaseshaping_oscillator_core_tb.sv
